@@ hdl/swarq_pkg.sv @@
// package: shared types and codes for the sliding-window arq sender
`default_nettype none

package swarq_pkg;

  typedef enum logic [1:0] {
    OP_OFFER   = 2'd0,
    OP_ACK     = 2'd1,
    OP_NACK    = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_e;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_END    = 3'd1;
  localparam logic [2:0] KIND_DONE   = 3'd2;
  localparam logic [2:0] KIND_ABORT  = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  localparam int unsigned SEQ_FIELD_W = 5;
  localparam logic [7:0] MAX_RETRIES_RST = 8'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] chunk_length;
    logic [7:0] chunk_tag;
    logic       chunk_final;
    logic [4:0] response_seq;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [4:0] frame_seq;
    logic [5:0] frame_length;
    logic [7:0] frame_tag;
    logic       last_of_burst;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_SHIFT,
    ST_PREP,
    ST_EMIT,
    ST_SINGLE
  } state_e;

  typedef struct packed {
    logic       latch;
    logic       offer_write;
    logic       end_write;
    logic       set_wait;
    logic       clr_wait;
    logic       clear_xfer;
    logic       retry_inc;
    logic       retry_clr;
    logic       fill_clr;
    logic       fill_sub;
    logic       idx_clr;
    logic       idx_inc;
    logic       found_cap;
    logic       shift_copy;
    logic       emit_slot;
    logic       emit_single;
    logic [2:0] single_kind;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic waiting;
    logic eof;
    logic endq;
    logic full;
    logic retry_ge;
    logic ack_match;
    logic idx_end;
    logic slot_hit;
    logic shift_end;
    logic slot_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/sliding_window_arq_sender.sv @@
// top level: sliding-window arq sender control, controller plus datapath
//
//   port group        dir  handshake            payload
//   in_item_i         in   in_valid_i/in_stall_o   op, chunk fields, response_seq
//   out_item_o        out  out_valid_o/out_stall_i result kind, frame fields, last
//   cfg_data_i        in   cfg_valid_i/cfg_ready_o max_retries
//
// an item is latched while idle and decoded in the next cycle; an offer is then
// decided and prepared, and emitted frames leave one per cycle while the output
// is free (up to WINDOW); a nack walks the slots one per cycle to find the frame
// and then moves the kept slots down one per cycle before the prepare step
// reset clears all control state; slot contents are not cleared
// a stalled result holds the output register; emission waits until it frees
`default_nettype none

module sliding_window_arq_sender #(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned SEQ_MODULUS = 32,
  parameter int unsigned PAYLOAD_MAX = 63
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire swarq_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output swarq_pkg::out_item_t      out_item_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [7:0]           cfg_data_i
);
  import swarq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  swarq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swarq_dp #(
    .WINDOW      (WINDOW),
    .SEQ_MODULUS (SEQ_MODULUS),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ hdl/swarq_ctrl.sv @@
// controller: sequences decode, nack search, window shift and emission
`default_nettype none

module swarq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire swarq_pkg::sts_t sts_i,
  output swarq_pkg::cmd_t      cmd_o
);
  import swarq_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_REJECT;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.single_kind = kind_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.op == OP_OFFER) begin
          if (sts_i.waiting || sts_i.eof || sts_i.full) begin
            kind_d  = KIND_REJECT;
            state_d = ST_SINGLE;
          end else begin
            cmd_o.offer_write = 1'b1;
            state_d = ST_PREP;
          end
        end else if (!sts_i.waiting) begin
          kind_d  = KIND_REJECT;
          state_d = ST_SINGLE;
        end else if (sts_i.op == OP_TIMEOUT) begin
          if (sts_i.retry_ge) begin
            cmd_o.clear_xfer = 1'b1;
            kind_d  = KIND_ABORT;
            state_d = ST_SINGLE;
          end else begin
            cmd_o.retry_inc = 1'b1;
            cmd_o.idx_clr   = 1'b1;
            state_d = ST_EMIT;
          end
        end else if (sts_i.op == OP_ACK) begin
          cmd_o.retry_clr = 1'b1;
          if (sts_i.ack_match) begin
            if (sts_i.endq) begin
              cmd_o.clear_xfer = 1'b1;
              kind_d  = KIND_DONE;
              state_d = ST_SINGLE;
            end else begin
              cmd_o.fill_clr = 1'b1;
              state_d = ST_PREP;
            end
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d = ST_EMIT;
          end
        end else begin
          cmd_o.retry_clr = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.idx_end) begin
          // named frame not held: drop the whole window
          cmd_o.fill_clr = 1'b1;
          state_d = ST_PREP;
        end else if (sts_i.slot_hit) begin
          cmd_o.found_cap = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          state_d = ST_SHIFT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (sts_i.shift_end) begin
          cmd_o.fill_sub = 1'b1;
          state_d = ST_PREP;
        end else begin
          cmd_o.shift_copy = 1'b1;
          cmd_o.idx_inc    = 1'b1;
        end
      end
      ST_PREP: begin
        if (!sts_i.eof && !sts_i.full) begin
          cmd_o.clr_wait = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.end_write = sts_i.eof && !sts_i.full && !sts_i.endq;
          cmd_o.set_wait  = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.idx_end) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_slot = 1'b1;
          if (sts_i.slot_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/swarq_dp.sv @@
// datapath: window slots, counters, flags, retry counter and output register
`default_nettype none

module swarq_dp #(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned SEQ_MODULUS = 32,
  parameter int unsigned PAYLOAD_MAX = 63
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire swarq_pkg::in_item_t  in_item_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire swarq_pkg::cmd_t      cmd_i,
  output swarq_pkg::sts_t           sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output swarq_pkg::out_item_t      out_item_o
);
  import swarq_pkg::*;

  localparam int unsigned IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned SW   = $clog2(SEQ_MODULUS);
  localparam int unsigned CMPW = (SW > SEQ_FIELD_W) ? SW : SEQ_FIELD_W;
  localparam logic [SW-1:0] SEQ_LAST = SW'(SEQ_MODULUS - 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(WINDOW);

  logic [SW-1:0] slot_seq_q    [WINDOW];
  logic [5:0]    slot_length_q [WINDOW];
  logic [7:0]    slot_tag_q    [WINDOW];
  logic          slot_end_q    [WINDOW];

  logic [CW-1:0] fill_q, idx_q, found_q;
  logic [SW-1:0] newest_q, seq_next;
  logic [7:0]    retry_q, max_retries_q;
  logic          eof_q, endq_q, wait_q;
  in_item_t      item_q;
  logic          out_valid_q;
  out_item_t     out_q;

  logic [CW:0]   shift_sum;
  logic [IW-1:0] rd_idx, wr_idx;
  logic [5:0]    sat_len;
  logic          out_free;

  assign seq_next  = (newest_q == SEQ_LAST) ? '0 : newest_q + SW'(1);
  assign shift_sum = (CW+1)'(found_q) + (CW+1)'(idx_q);
  assign rd_idx    = (cmd_i.shift_copy) ? shift_sum[IW-1:0] : idx_q[IW-1:0];
  assign wr_idx    = (cmd_i.shift_copy) ? idx_q[IW-1:0] : fill_q[IW-1:0];
  assign sat_len   = (int'(item_q.chunk_length) > PAYLOAD_MAX) ? 6'(PAYLOAD_MAX)
                                                               : item_q.chunk_length;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.op        = op_e'(item_q.op);
    sts_o.waiting   = wait_q;
    sts_o.eof       = eof_q;
    sts_o.endq      = endq_q;
    sts_o.full      = (fill_q >= FILL_MAX);
    sts_o.retry_ge  = (retry_q >= max_retries_q);
    sts_o.ack_match = (SEQ_FIELD_W'(newest_q) == item_q.response_seq);
    sts_o.idx_end   = (idx_q >= fill_q);
    sts_o.slot_hit  = (CMPW'(slot_seq_q[idx_q[IW-1:0]]) == CMPW'(item_q.response_seq));
    sts_o.shift_end = (shift_sum >= (CW+1)'(fill_q));
    sts_o.slot_last = ((CW+1)'(idx_q) + (CW+1)'(1) >= (CW+1)'(fill_q))
                      || slot_end_q[idx_q[IW-1:0]];
    sts_o.out_free  = out_free;
  end

  // slot storage, written at fill for new frames or at idx while shifting
  always_ff @(posedge clk_i) begin
    if (cmd_i.offer_write) begin
      slot_seq_q[wr_idx]    <= seq_next;
      slot_length_q[wr_idx] <= sat_len;
      slot_tag_q[wr_idx]    <= item_q.chunk_tag;
      slot_end_q[wr_idx]    <= 1'b0;
    end else if (cmd_i.end_write) begin
      slot_seq_q[wr_idx]    <= seq_next;
      slot_length_q[wr_idx] <= '0;
      slot_tag_q[wr_idx]    <= '0;
      slot_end_q[wr_idx]    <= 1'b1;
    end else if (cmd_i.shift_copy) begin
      slot_seq_q[wr_idx]    <= slot_seq_q[rd_idx];
      slot_length_q[wr_idx] <= slot_length_q[rd_idx];
      slot_tag_q[wr_idx]    <= slot_tag_q[rd_idx];
      slot_end_q[wr_idx]    <= slot_end_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    if (cmd_i.emit_slot) begin
      out_q.result_kind   <= slot_end_q[rd_idx] ? KIND_END : KIND_DATA;
      out_q.frame_seq     <= SEQ_FIELD_W'(slot_seq_q[rd_idx]);
      out_q.frame_length  <= slot_length_q[rd_idx];
      out_q.frame_tag     <= slot_tag_q[rd_idx];
      out_q.last_of_burst <= sts_o.slot_last;
    end else if (cmd_i.emit_single) begin
      out_q.result_kind   <= cmd_i.single_kind;
      out_q.frame_seq     <= '0;
      out_q.frame_length  <= '0;
      out_q.frame_tag     <= '0;
      out_q.last_of_burst <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      idx_q         <= '0;
      found_q       <= '0;
      newest_q      <= SEQ_LAST;
      retry_q       <= '0;
      max_retries_q <= MAX_RETRIES_RST;
      eof_q         <= 1'b0;
      endq_q        <= 1'b0;
      wait_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_retries_q <= cfg_data_i;
      end
      if (cmd_i.emit_slot || cmd_i.emit_single) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.found_cap) begin
        found_q <= idx_q;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.retry_inc) begin
        retry_q <= retry_q + 8'd1;
      end else if (cmd_i.retry_clr) begin
        retry_q <= '0;
      end
      if (cmd_i.set_wait) begin
        wait_q <= 1'b1;
      end else if (cmd_i.clr_wait) begin
        wait_q <= 1'b0;
      end
      if (cmd_i.offer_write) begin
        newest_q <= seq_next;
        fill_q   <= fill_q + CW'(1);
        if (item_q.chunk_final) begin
          eof_q <= 1'b1;
        end
      end else if (cmd_i.end_write) begin
        newest_q <= seq_next;
        fill_q   <= fill_q + CW'(1);
        endq_q   <= 1'b1;
      end else if (cmd_i.fill_clr) begin
        fill_q <= '0;
      end else if (cmd_i.fill_sub) begin
        fill_q <= fill_q - found_q;
      end
      // end of transfer: fill, newest sequence, retry count and flags back to reset values
      if (cmd_i.clear_xfer) begin
        fill_q   <= '0;
        newest_q <= SEQ_LAST;
        retry_q  <= '0;
        eof_q    <= 1'b0;
        endq_q   <= 1'b0;
        wait_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("window fill above its size");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_xfer |=> (fill_q == '0) && !wait_q && !eof_q && !endq_q)
    else $error("transfer state not cleared");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result lost");

  a_shift_from_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_copy |-> (shift_sum < (CW+1)'(fill_q)))
    else $error("shift reads beyond the window");

endmodule

`default_nettype wire
